// ----- rtl/tref_pkg.sv -----
// ----------------------------------------------------------------------------
// tref_pkg: shared types and constants of the tagged record endian fixer
// Parse phases, byte role codes, order markers and the type width lookup.
// ----------------------------------------------------------------------------
package tref_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_MARKER  = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_NAME    = 3'd2;
  localparam logic [2:0] PH_TYPE    = 3'd3;
  localparam logic [2:0] PH_LEN     = 3'd4;
  localparam logic [2:0] PH_CONTENT = 3'd5;
  localparam logic [2:0] PH_HOLD    = 3'd6;

  // Byte role codes carried with every output word
  localparam logic [2:0] ROLE_MARKER  = 3'd0;
  localparam logic [2:0] ROLE_NAME    = 3'd1;
  localparam logic [2:0] ROLE_TYPE    = 3'd2;
  localparam logic [2:0] ROLE_LENGTH  = 3'd3;
  localparam logic [2:0] ROLE_CONTENT = 3'd4;

  // Order markers
  localparam logic [7:0] MARK_BIG    = 8'd66;  // 'B'
  localparam logic [7:0] MARK_LITTLE = 8'd76;  // 'L'

  // Width in bytes of the leading content value that gets reordered.
  // Types 4/5 carry 16-bit values, 6/7 carry 32-bit values, others none.
  function automatic logic [2:0] type_width(input logic [7:0] t);
    logic [2:0] w;
    case (t)
      8'd4, 8'd5: w = 3'd2;
      8'd6, 8'd7: w = 3'd4;
      default:    w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tagged_record_endian_fixer.sv -----
// ----------------------------------------------------------------------------
// tagged_record_endian_fixer: byte-order fixer for a tagged record buffer
// Parses marker / name / type / length / content bytes, swaps multi-byte
// fields when the buffer order differs from the host order, tags each byte.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata tlast     tdata[7:0] data_byte, tlast last_byte
// m_axis    out  tvalid tready tdata tuser     tdata: out_byte, record_type,
//                tlast                         record_length; tuser: role,
//                                              swapped, truncated; tlast run_last
// cfg       in   cfg_we_i cfg_wdata_i          host_big_endian
//
// Cycles: each accepted byte is decoded in the cycle it is taken; its 0..4
// result words land in a burst register and leave one word per cycle.
// A byte that yields n words keeps s_axis_tready low while more than one word is left;
// the next byte is taken in the same cycle as the last word of the burst.
// Bytes that are held back (length field, swapped content) yield no word and
// never stall. Reset clears the parse state; the first byte is a marker.
// A stalled m_axis holds the current word and the rest of its burst.
//
module tagged_record_endian_fixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // host_big_endian
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // last_byte
  // output word stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // [7:0] out_byte, [15:8] record_type,
                                       // [47:16] record_length
  output logic [4:0]  m_axis_tuser,    // [2:0] byte_role, [3] was_swapped,
                                       // [4] truncated
  output logic        m_axis_tlast     // run_last
);

  import tref_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration and parse state
  // --------------------------------------------------------------------------
  logic        host_be_q;
  logic [2:0]  phase_q, phase_d;
  logic        swap_q, swap_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] len_q, len_d;          // decoded length of current record
  logic [31:0] rem_q, rem_d;          // content bytes still to come
  logic [7:0]  hold_q [4];            // held-back bytes, written before read
  logic [7:0]  hold_d [4];
  logic [2:0]  hcnt_q, hcnt_d;

  // --------------------------------------------------------------------------
  // Burst register: up to four words that share everything but the byte
  // --------------------------------------------------------------------------
  logic [7:0]  bbyte_q [4];
  logic [2:0]  bleft_q;               // words still to send
  logic [1:0]  brd_q;                 // next word to send
  logic [2:0]  brole_q;
  logic [7:0]  btype_q;
  logic [31:0] blen_q;
  logic        bsw_q;
  logic        btrunc_q;

  // Burst produced by the byte at the input
  logic [7:0]  nbyte [4];
  logic [2:0]  ncnt;
  logic [2:0]  nrole;
  logic [7:0]  ntype;
  logic [31:0] nlen;
  logic        nsw;
  logic        ntrunc;

  logic        acc, pop;
  logic [7:0]  b;
  logic [7:0]  host_mark;
  logic [7:0]  hb [4];                // held bytes with b dropped in at hcnt
  logic [2:0]  hcnt_inc;
  logic [31:0] rem_dec;
  logic [31:0] len_new;
  logic [2:0]  w;

  assign b         = s_axis_tdata;
  assign acc       = s_axis_tvalid && s_axis_tready;
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign host_mark = host_be_q ? MARK_BIG : MARK_LITTLE;
  assign hcnt_inc  = hcnt_q + 3'd1;
  assign rem_dec   = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
  assign w         = type_width(type_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hb[i] = (hcnt_q[1:0] == 2'(i)) ? b : hold_q[i];
    end
  end

  // Length field, read when its fourth byte arrives
  assign len_new = (host_be_q ^ swap_q) ? {hold_q[0], hold_q[1], hold_q[2], b}
                                        : {b, hold_q[2], hold_q[1], hold_q[0]};

  // --------------------------------------------------------------------------
  // Decode of one byte
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    swap_d  = swap_q;
    type_d  = type_q;
    len_d   = len_q;
    rem_d   = rem_q;
    hcnt_d  = hcnt_q;
    for (int i = 0; i < 4; i++) begin
      hold_d[i] = hold_q[i];
      nbyte[i]  = hb[i];
    end
    ncnt   = 3'd0;
    nrole  = ROLE_MARKER;
    ntype  = 8'd0;
    nlen   = 32'd0;
    nsw    = 1'b0;
    ntrunc = 1'b0;

    case (phase_q)
      PH_MARKER: begin
        swap_d   = (b != host_mark);
        // a lone marker that ends the buffer passes unchanged
        nbyte[0] = s_axis_tlast ? b : host_mark;
        ncnt     = 3'd1;
        hcnt_d   = 3'd0;
        phase_d  = PH_START;
      end
      PH_START, PH_NAME: begin
        nbyte[0] = b;
        ncnt     = 3'd1;
        nrole    = ROLE_NAME;
        phase_d  = (b == 8'd0) ? PH_TYPE : PH_NAME;
      end
      PH_TYPE: begin
        type_d   = b;
        nbyte[0] = b;
        ncnt     = 3'd1;
        nrole    = ROLE_TYPE;
        ntype    = b;
        hcnt_d   = 3'd0;
        phase_d  = PH_LEN;
      end
      PH_LEN: begin
        nrole = ROLE_LENGTH;
        ntype = type_q;
        if (hcnt_q < 3'd3) begin
          hold_d[hcnt_q[1:0]] = b;
          hcnt_d              = hcnt_inc;
          if (s_axis_tlast) begin
            // cut length field: release in arrival order, length unknown
            ncnt   = hcnt_inc;
            hcnt_d = 3'd0;
          end
        end else begin
          hcnt_d = 3'd0;
          len_d  = len_new;
          rem_d  = len_new;
          nlen   = len_new;
          nsw    = swap_q;
          ncnt   = 3'd4;
          for (int i = 0; i < 4; i++) begin
            nbyte[i] = swap_q ? hb[3-i] : hb[i];
          end
          if (len_new == 32'd0) begin
            phase_d = PH_START;
          end else if (swap_q && w != 3'd0 && len_new >= 32'(w)) begin
            phase_d = PH_HOLD;
          end else begin
            phase_d = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        nbyte[0] = b;
        ncnt     = 3'd1;
        nrole    = ROLE_CONTENT;
        ntype    = type_q;
        nlen     = len_q;
        rem_d    = rem_dec;
        phase_d  = (rem_dec != 32'd0) ? PH_CONTENT : PH_START;
      end
      PH_HOLD: begin
        nrole               = ROLE_CONTENT;
        ntype               = type_q;
        nlen                = len_q;
        hold_d[hcnt_q[1:0]] = b;
        hcnt_d              = hcnt_inc;
        rem_d               = rem_dec;
        if (hcnt_inc >= ((w == 3'd0) ? 3'd2 : w)) begin
          // value complete: send it reversed
          nsw    = 1'b1;
          hcnt_d = 3'd0;
          if (w == 3'd4) begin
            ncnt = 3'd4;
            for (int i = 0; i < 4; i++) begin
              nbyte[i] = hb[3-i];
            end
          end else begin
            ncnt     = 3'd2;
            nbyte[0] = hb[1];
            nbyte[1] = hb[0];
          end
          phase_d = (rem_dec != 32'd0) ? PH_CONTENT : PH_START;
        end else if (s_axis_tlast) begin
          ncnt   = hcnt_inc;
          hcnt_d = 3'd0;
        end
      end
      default: begin
        phase_d = PH_MARKER;
      end
    endcase

    // end of buffer: flag a cut record, expect a new marker
    if (s_axis_tlast) begin
      ntrunc  = (phase_d != PH_START) && (phase_d != PH_MARKER);
      phase_d = PH_MARKER;
      hcnt_d  = 3'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_be_q <= 1'b0;
    end else if (cfg_we_i) begin
      host_be_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MARKER;
      swap_q  <= 1'b0;
      type_q  <= 8'd0;
      len_q   <= 32'd0;
      rem_q   <= 32'd0;
      hcnt_q  <= 3'd0;
    end else if (acc) begin
      phase_q <= phase_d;
      swap_q  <= swap_d;
      type_q  <= type_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      hcnt_q  <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int i = 0; i < 4; i++) begin
        hold_q[i] <= hold_d[i];
      end
    end
  end

  // burst control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bleft_q <= 3'd0;
      brd_q   <= 2'd0;
    end else if (acc && ncnt != 3'd0) begin
      bleft_q <= ncnt;
      brd_q   <= 2'd0;
    end else if (pop) begin
      bleft_q <= bleft_q - 3'd1;
      brd_q   <= brd_q + 2'd1;
    end
  end

  // burst payload
  always_ff @(posedge clk_i) begin
    if (acc && ncnt != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        bbyte_q[i] <= nbyte[i];
      end
      brole_q  <= nrole;
      btype_q  <= ntype;
      blen_q   <= nlen;
      bsw_q    <= nsw;
      btrunc_q <= ntrunc;
    end
  end

  // take a byte when the burst is empty or its last word leaves now
  assign s_axis_tready = (bleft_q == 3'd0) || (bleft_q == 3'd1 && m_axis_tready);

  assign m_axis_tvalid = (bleft_q != 3'd0);
  assign m_axis_tlast  = (bleft_q == 3'd1);
  assign m_axis_tdata  = {blen_q, btype_q, bbyte_q[brd_q]};
  assign m_axis_tuser  = {btrunc_q && (bleft_q == 3'd1), bsw_q, brole_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bleft_q <= 3'd4)
    else $error("burst count above four");

  a_len_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == PH_LEN && hcnt_q == 3'd3) |=> (bleft_q == 3'd4))
    else $error("complete length field did not give four words");

  a_last_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> (phase_q == PH_MARKER && hcnt_q == 3'd0))
    else $error("parser not back at marker after last byte");

  a_swap_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |-> swap_q)
    else $error("swapped word while swapping is off");

  a_hold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HOLD) |-> (hcnt_q < 3'd4))
    else $error("hold count overflow");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tagged_record_endian_fixer
// Feeds byte buffers (marker, records, content) under both host orders and
// checks every output word against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module testbench;
  import tref_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;   // burst register depth plus margin
  localparam int MAX_PRINTS = 32;

  // One output word as seen on m_axis, split into its fields
  typedef struct {
    logic [7:0]  data;
    logic [2:0]  role;
    logic [7:0]  rtype;
    logic [31:0] rlen;
    logic        swapped;
    logic        trunc;
    logic        burst_end;
  } fixed_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // [7:0] out_byte, [15:8] record_type, [47:16] record_length
  logic [4:0]  m_axis_tuser;   // [2:0] byte_role, [3] was_swapped, [4] truncated
  logic        m_axis_tlast;   // run_last

  // Parser shadow state, updated once per accepted byte
  logic        host_be = 1'b0;
  logic [2:0]  prs_phase = PH_MARKER;
  logic        prs_swap = 1'b0;
  logic [7:0]  prs_type = 8'h00;
  logic [31:0] prs_len = '0;
  logic [31:0] prs_left = '0;
  logic [7:0]  prs_hold [4];
  logic [2:0]  prs_hold_cnt = '0;

  fixed_word_t pending_words [$];   // expected words, oldest first
  logic [7:0]  buf_q [$];           // buffer under construction

  // Pacing knobs
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int sink_gap = 0;
  int sink_hold_left = 0;   // long receiver stall, counted down by the sink

  // Bookkeeping
  int cycle_cnt = 0;
  int err_cnt = 0;
  int n_bytes = 0;
  int n_buffers = 0;
  int n_words = 0;
  int n_host_writes = 0;

  tagged_record_endian_fixer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Hang guard: a correct run ends far below this
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_cnt, pending_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  function automatic fixed_word_t mk_word(logic [7:0] d, logic [2:0] role, logic [7:0] t,
                                          logic [31:0] len, logic sw);
    fixed_word_t w;
    w.data = d;
    w.role = role;
    w.rtype = t;
    w.rlen = len;
    w.swapped = sw;
    w.trunc = 1'b0;
    w.burst_end = 1'b0;
    return w;
  endfunction

  // Bytes of the leading value that get reordered for a given record type
  function automatic int swap_span(logic [7:0] t);
    case (t)
      8'd4, 8'd5: return 2;
      8'd6, 8'd7: return 4;
      default:    return 0;
    endcase
  endfunction

  // Runs one accepted byte through the shadow parser and queues its words
  function automatic void fix_byte_order(logic [7:0] b, logic lst);
    fixed_word_t res [4];
    int n;
    int span;
    logic [7:0] hmark;
    n = 0;
    hmark = host_be ? MARK_BIG : MARK_LITTLE;
    case (prs_phase)
      PH_MARKER: begin
        prs_swap = (b != hmark);
        // a marker that is also the last byte passes through untouched
        res[n++] = mk_word(lst ? b : hmark, ROLE_MARKER, 8'h00, '0, 1'b0);
        prs_hold_cnt = '0;
        prs_phase = PH_START;
      end
      PH_START, PH_NAME: begin
        res[n++] = mk_word(b, ROLE_NAME, 8'h00, '0, 1'b0);
        prs_phase = (b == 8'h00) ? PH_TYPE : PH_NAME;
      end
      PH_TYPE: begin
        prs_type = b;
        res[n++] = mk_word(b, ROLE_TYPE, prs_type, '0, 1'b0);
        prs_hold_cnt = '0;
        prs_phase = PH_LEN;
      end
      PH_LEN: begin
        if (prs_hold_cnt < 3) begin
          prs_hold[prs_hold_cnt[1:0]] = b;
          prs_hold_cnt++;
          // cut length field: flush what we have, in order, with no length
          if (lst) begin
            for (int i = 0; i < prs_hold_cnt; i++)
              res[n++] = mk_word(prs_hold[i], ROLE_LENGTH, prs_type, '0, 1'b0);
            prs_hold_cnt = '0;
          end
        end else begin
          prs_hold[3] = b;
          prs_hold_cnt = '0;
          if (host_be ^ prs_swap)
            prs_len = {prs_hold[0], prs_hold[1], prs_hold[2], prs_hold[3]};
          else
            prs_len = {prs_hold[3], prs_hold[2], prs_hold[1], prs_hold[0]};
          for (int i = 0; i < 4; i++)
            res[n++] = mk_word(prs_swap ? prs_hold[3-i] : prs_hold[i], ROLE_LENGTH,
                               prs_type, prs_len, prs_swap);
          prs_left = prs_len;
          span = swap_span(prs_type);
          if (prs_left == 0)
            prs_phase = PH_START;
          else if (prs_swap && span != 0 && prs_left >= span)
            prs_phase = PH_HOLD;
          else
            prs_phase = PH_CONTENT;   // includes content shorter than the type
        end
      end
      PH_CONTENT: begin
        res[n++] = mk_word(b, ROLE_CONTENT, prs_type, prs_len, 1'b0);
        if (prs_left != 0) prs_left--;
        prs_phase = (prs_left != 0) ? PH_CONTENT : PH_START;
      end
      default: begin   // holding the leading content value
        span = swap_span(prs_type);
        if (span == 0) span = 2;
        prs_hold[prs_hold_cnt[1:0]] = b;
        prs_hold_cnt++;
        if (prs_left != 0) prs_left--;
        if (prs_hold_cnt >= span) begin
          for (int i = 0; i < span; i++)
            res[n++] = mk_word(prs_hold[(span-1-i) & 3], ROLE_CONTENT, prs_type, prs_len, 1'b1);
          prs_hold_cnt = '0;
          prs_phase = (prs_left != 0) ? PH_CONTENT : PH_START;
        end else if (lst) begin
          for (int i = 0; i < prs_hold_cnt; i++)
            res[n++] = mk_word(prs_hold[i], ROLE_CONTENT, prs_type, prs_len, 1'b0);
          prs_hold_cnt = '0;
        end
      end
    endcase

    if (lst) begin
      if (n > 0 && prs_phase != PH_START && prs_phase != PH_MARKER)
        res[n-1].trunc = 1'b1;
      prs_phase = PH_MARKER;
      prs_hold_cnt = '0;
    end
    if (n > 0) res[n-1].burst_end = 1'b1;
    for (int i = 0; i < n; i++) pending_words.push_back(res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: pacing and checking
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin : sink_pacing
    logic rdy;
    if (m_axis_tvalid && m_axis_tready)
      sink_gap = rx_idle_en ? $urandom_range(0, 9) : 0;
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      rdy = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : word_checker
    fixed_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (pending_words.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        want = pending_words.pop_front();
        check_field("out_byte",      32'(m_axis_tdata[7:0]),  32'(want.data));
        check_field("record_type",   32'(m_axis_tdata[15:8]), 32'(want.rtype));
        check_field("record_length", m_axis_tdata[47:16],     want.rlen);
        check_field("byte_role",     32'(m_axis_tuser[2:0]),  32'(want.role));
        check_field("was_swapped",   32'(m_axis_tuser[3]),    32'(want.swapped));
        check_field("truncated",     32'(m_axis_tuser[4]),    32'(want.trunc));
        check_field("run_last",      32'(m_axis_tlast),       32'(want.burst_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one byte and returns at the edge that takes it
  task automatic send_byte(input logic [7:0] d, input logic lst);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    fix_byte_order(d, lst);
    n_bytes++;
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
    n_buffers++;
  endtask

  // Sender stops; returns once every expected word is out and the block is quiet
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_host_order(input logic be);
    wait_results_done();
    cfg_wdata_i <= be;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    host_be = be;
    n_host_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Builds one buffer in buf_q. Mostly well-formed records with random
  // names, types and contents; some one-byte buffers, some cut short at a
  // random byte, some with a garbage length field.
  task automatic make_buffer();
    int kind;
    int r;
    logic [7:0] mk;
    logic [7:0] t;
    logic [31:0] len;
    logic lsb_last;
    buf_q.delete();
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    mk = (r < 4) ? MARK_BIG : (r < 8) ? MARK_LITTLE : 8'($urandom_range(0, 255));
    buf_q.push_back(mk);
    if (kind < 5) return;
    // length bytes must be laid out in the order the block will decode
    lsb_last = host_be ^ (mk != (host_be ? MARK_BIG : MARK_LITTLE));
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom_range(1, 255)));
      buf_q.push_back(8'h00);
      r = $urandom_range(0, 9);
      t = (r < 6) ? 8'($urandom_range(4, 7)) :
          (r < 8) ? 8'($urandom_range(0, 9)) : 8'($urandom_range(0, 255));
      buf_q.push_back(t);
      if (kind >= 90) begin
        len = $urandom;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
      end
      for (int i = 0; i < 4; i++)
        buf_q.push_back(lsb_last ? len[8*(3-i) +: 8] : len[8*i +: 8]);
      if (kind >= 90) begin
        // huge or odd length: a few content bytes, then the buffer just ends
        repeat ($urandom_range(0, 5)) buf_q.push_back(8'($urandom_range(0, 255)));
        break;
      end
      repeat (len) buf_q.push_back(8'($urandom_range(0, 255)));
    end
    if (kind >= 75 && kind < 90 && buf_q.size() > 2) begin
      r = $urandom_range(1, buf_q.size() - 1);
      while (buf_q.size() > r) void'(buf_q.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Host order little: a lone marker, a swapped 16-bit record, a 32-bit
  // record too short to swap, and a length field cut by the buffer end.
  task automatic test_directed_cases();
    buf_q = '{MARK_BIG};
    send_buffer();
    buf_q = '{MARK_BIG, 8'hFF, 8'h00, 8'd5, 8'h00, 8'h00, 8'h00, 8'h02, 8'h12, 8'h34};
    send_buffer();
    buf_q = '{MARK_BIG, 8'h00, 8'd7, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAB,
              8'h00, 8'd6, 8'h80, 8'h7F};
    send_buffer();
  endtask

  task automatic test_random_buffers(input int n_items);
    int start;
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      make_buffer();
      send_buffer();
    end
  endtask

  // Receiver goes dark while bytes keep coming: the burst register fills
  // and s_axis_tready must drop until the sink wakes up.
  task automatic test_output_stall();
    sink_hold_left = 150;
    test_random_buffers(40);
    wait_results_done();
  endtask

  // Both sides run flat out
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_buffers(60);
    wait_results_done();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_host_order(1'b0);
    test_directed_cases();
    set_host_order(1'b1);
    test_random_buffers(130);
    test_output_stall();
    set_host_order(1'b0);
    test_random_buffers(120);
    set_host_order(1'b1);
    test_back_to_back();
    set_host_order(1'b0);
    test_random_buffers(40);

    wait_results_done();
    $display("sent %0d bytes in %0d buffers, checked %0d words", n_bytes, n_buffers, n_words);
    $display("host order written %0d times, with stalls, a long sink hold and full rate",
             n_host_writes);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
